// File: rtl/lrd_pkg.sv
// ----------------------------------------------------------------------------
// lrd_pkg: shared types and constants for the line rasterizer with depth
// Holds field widths, request payload structs, register indexes and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lrd_pkg;

	// Field widths.
	localparam int COORD_BITS   = 12;
	localparam int DEPTH_BITS   = 32;
	localparam int DIM_BITS     = 11;
	localparam int DIFF_BITS    = COORD_BITS + 1;
	localparam int SLOPE_BITS   = COORD_BITS + 2;
	localparam int DEC_BITS     = COORD_BITS + 6;
	localparam int CNT_BITS     = $clog2(DEPTH_BITS);
	localparam int CFG_IDX_BITS = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_BITS'(1);

	// Request kinds.
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// Window size after reset.
	localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(500);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DEPTH_BITS-1:0] depth_t;
	typedef logic [DIM_BITS-1:0]          dim_t;

	typedef struct packed {
		logic   kind;
		coord_t start_x;
		coord_t start_y;
		depth_t start_depth;
		coord_t end_x;
		coord_t end_y;
		depth_t end_depth;
	} item_t;

	typedef struct packed {
		coord_t pixel_x;
		coord_t pixel_y;
		depth_t pixel_depth;
		logic   visible;
		logic   last;
	} pixel_t;

	typedef struct packed {
		logic load;
		logic tick;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_stall;
	} ctrl_status_t;

endpackage

// File: rtl/lrd_intf.sv
// ----------------------------------------------------------------------------
// lrd_intf: valid/ready channels of the line rasterizer
// Input request channel, pixel result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface lrd_item_if;
	logic          valid;
	logic          ready;
	lrd_pkg::item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lrd_pixel_if;
	logic            valid;
	logic            ready;
	lrd_pkg::pixel_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lrd_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [lrd_pkg::CFG_IDX_BITS-1:0] index;
	lrd_pkg::dim_t                     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/lrd_div.sv
// ----------------------------------------------------------------------------
// lrd_div: iterative signed divider for the per-step depth change
// Restoring division of a 32-bit magnitude by the step count, one quotient
// bit per cycle, with the sign applied at the end. A zero divisor gives zero.
// ----------------------------------------------------------------------------
module lrd_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [lrd_pkg::DEPTH_BITS-1:0]       dividend,
	input  logic                                 negative,
	input  logic [lrd_pkg::COORD_BITS-1:0]       divisor,
	output logic                                 done,
	output logic [lrd_pkg::DEPTH_BITS-1:0]       quotient
);

	localparam logic [lrd_pkg::CNT_BITS-1:0] CNT_LAST =
		lrd_pkg::CNT_BITS'(lrd_pkg::DEPTH_BITS - 1);

	logic                               busy_q;
	logic                               done_q;
	logic [lrd_pkg::CNT_BITS-1:0]       cnt_q;
	logic [lrd_pkg::COORD_BITS-1:0]     rem_q;
	logic [lrd_pkg::COORD_BITS-1:0]     div_q;
	logic [lrd_pkg::DEPTH_BITS-1:0]     quo_q;
	logic                               neg_q;
	logic                               zero_q;
	logic [lrd_pkg::COORD_BITS:0]       trial;
	logic                               fits;
	logic [lrd_pkg::COORD_BITS:0]       trial_sub;

	// One restoring step: bring down the next dividend bit and try a subtract.
	always_comb begin
		trial     = {rem_q, quo_q[lrd_pkg::DEPTH_BITS-1]};
		fits      = trial >= {1'b0, div_q};
		trial_sub = trial - {1'b0, div_q};
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			div_q  <= divisor;
			neg_q  <= negative;
			zero_q <= (divisor == '0);
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[lrd_pkg::COORD_BITS-1:0]
			              : trial[lrd_pkg::COORD_BITS-1:0];
			quo_q <= {quo_q[lrd_pkg::DEPTH_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = zero_q ? '0 : (neg_q ? -quo_q : quo_q);

	// The finish pulse only comes at the end of a run.
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("divider finished while still busy");

endmodule

// File: rtl/lrd_dpath.sv
// ----------------------------------------------------------------------------
// lrd_dpath: datapath of the line rasterizer
// Line setup on load, the stepping registers, the depth divider, the window
// registers and the pixel output register.
// ----------------------------------------------------------------------------
module lrd_dpath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lrd_pkg::item_t        item_data,
	input  lrd_pkg::ctrl_cmd_t    cmd,
	output lrd_pkg::ctrl_status_t status,
	lrd_cfg_if.sink               cfg,
	lrd_pixel_if.source           pixel
);

	localparam int CB = lrd_pkg::COORD_BITS;

	// Window registers.
	lrd_pkg::dim_t width_q;
	lrd_pkg::dim_t height_q;

	// Line state.
	logic                              active_q;
	lrd_pkg::coord_t                   cur_x_q;
	lrd_pkg::coord_t                   cur_y_q;
	lrd_pkg::depth_t                   cur_depth_q;
	lrd_pkg::depth_t                   depth_step_q;
	logic signed [lrd_pkg::DEC_BITS-1:0]   dec_q;
	logic signed [lrd_pkg::SLOPE_BITS-1:0] slope_q;
	logic signed [lrd_pkg::DEC_BITS-1:0]   diag_step_q;
	logic signed [lrd_pkg::DEC_BITS-1:0]   east_step_q;
	logic                              east_dx_q;
	logic signed [1:0]                 east_dy_q;
	logic signed [1:0]                 diag_dy_q;
	logic                              wide_q;
	logic [CB-1:0]                     steps_left_q;

	// Output register.
	logic            out_valid_q;
	lrd_pkg::pixel_t out_q;

	// Setup signals.
	logic                                  swap;
	lrd_pkg::coord_t                       x0, y0, x1, y1;
	lrd_pkg::depth_t                       z0, z1;
	logic signed [lrd_pkg::DIFF_BITS-1:0]  dx, dy, ady;
	logic signed [lrd_pkg::DEC_BITS-1:0]   dx_d, dy_d, dx2_d, a_d;
	logic signed [lrd_pkg::SLOPE_BITS-1:0] slope_n;
	logic                                  wide_n, a_pos;
	logic [CB-1:0]                         steps_n;
	logic signed [lrd_pkg::DEC_BITS-1:0]   dec_n, diag_step_n, east_step_n;
	logic signed [1:0]                     east_dy_n, diag_dy_n;
	logic signed [lrd_pkg::DEPTH_BITS:0]   zdiff, zdiff_neg;
	logic [lrd_pkg::DEPTH_BITS-1:0]        zmag;

	// Stepping signals.
	logic                                  diag;
	logic                                  slope_pos, slope_neg, dec_pos, dec_neg;
	lrd_pkg::coord_t                       w_lim, h_lim;
	logic                                  vis;
	logic                                  last_px;
	logic                                  emit;

	// Divider connection.
	logic                            div_done;
	logic [lrd_pkg::DEPTH_BITS-1:0]  div_quo;

	// Line setup: order endpoints by x, choose the octant, set decision terms.
	always_comb begin
		swap = item_data.start_x > item_data.end_x;
		x0   = swap ? item_data.end_x       : item_data.start_x;
		y0   = swap ? item_data.end_y       : item_data.start_y;
		z0   = swap ? item_data.end_depth   : item_data.start_depth;
		x1   = swap ? item_data.start_x     : item_data.end_x;
		y1   = swap ? item_data.start_y     : item_data.end_y;
		z1   = swap ? item_data.start_depth : item_data.end_depth;

		dx      = lrd_pkg::DIFF_BITS'(x1) - lrd_pkg::DIFF_BITS'(x0);
		dy      = lrd_pkg::DIFF_BITS'(y1) - lrd_pkg::DIFF_BITS'(y0);
		ady     = dy[lrd_pkg::DIFF_BITS-1] ? -dy : dy;
		wide_n  = dx >= ady;
		a_pos   = dy > 0;
		slope_n = {dy, 1'b0};

		dx_d  = lrd_pkg::DEC_BITS'(dx);
		dy_d  = lrd_pkg::DEC_BITS'(dy);
		dx2_d = dx_d + dx_d;
		a_d   = dy_d + dy_d;

		steps_n = wide_n ? dx[CB-1:0] : ady[CB-1:0];

		priority if (wide_n && a_pos) begin
			dec_n       = a_d - dx_d;
			diag_step_n = a_d - dx2_d;
			east_step_n = a_d;
			east_dy_n   = 2'sd0;
			diag_dy_n   = 2'sd1;
		end else if (wide_n) begin
			dec_n       = a_d + dx_d;
			diag_step_n = a_d + dx2_d;
			east_step_n = a_d;
			east_dy_n   = 2'sd0;
			diag_dy_n   = -2'sd1;
		end else if (a_pos) begin
			dec_n       = dy_d - dx2_d;
			diag_step_n = a_d - dx2_d;
			east_step_n = -dx2_d;
			east_dy_n   = 2'sd1;
			diag_dy_n   = 2'sd1;
		end else begin
			dec_n       = dy_d + dx2_d;
			diag_step_n = a_d + dx2_d;
			east_step_n = dx2_d;
			east_dy_n   = -2'sd1;
			diag_dy_n   = -2'sd1;
		end

		// Exact depth difference and its magnitude for the divider.
		zdiff     = (lrd_pkg::DEPTH_BITS + 1)'(z1) - (lrd_pkg::DEPTH_BITS + 1)'(z0);
		zdiff_neg = -zdiff;
		zmag      = zdiff[lrd_pkg::DEPTH_BITS] ? zdiff_neg[lrd_pkg::DEPTH_BITS-1:0]
		                                       : zdiff[lrd_pkg::DEPTH_BITS-1:0];
	end

	lrd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.load),
		.dividend (zmag),
		.negative (zdiff[lrd_pkg::DEPTH_BITS]),
		.divisor  (steps_n),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Step decision and visibility of the current pixel.
	always_comb begin
		slope_pos = slope_q > 0;
		slope_neg = slope_q[lrd_pkg::SLOPE_BITS-1];
		dec_pos   = dec_q > 0;
		dec_neg   = dec_q[lrd_pkg::DEC_BITS-1];
		diag      = wide_q ? ((slope_pos && dec_pos) || (slope_neg && dec_neg))
		                   : ((slope_pos && dec_neg) || (slope_neg && dec_pos));

		w_lim   = CB'(width_q);
		h_lim   = CB'(height_q);
		vis     = (cur_x_q > 0) && (cur_x_q < w_lim) && (cur_y_q > 0) && (cur_y_q < h_lim);
		last_px = steps_left_q == '0;
		emit    = cmd.tick && active_q;
	end

	// Window registers take writes at any time; unknown indexes are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lrd_pkg::DIM_RESET;
			height_q <= lrd_pkg::DIM_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				lrd_pkg::CFG_IMAGE_WIDTH: begin
					width_q <= cfg.data;
				end
				lrd_pkg::CFG_IMAGE_HEIGHT: begin
					height_q <= cfg.data;
				end
				default: begin
				end
			endcase
		end
	end

	// Line activity and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				active_q <= 1'b1;
			end else if (emit && last_px) begin
				active_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pixel.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Line registers: loaded on setup, advanced on each emitted pixel but the last.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_x_q      <= x0;
			cur_y_q      <= y0;
			cur_depth_q  <= z0;
			dec_q        <= dec_n;
			slope_q      <= slope_n;
			diag_step_q  <= diag_step_n;
			east_step_q  <= east_step_n;
			east_dx_q    <= wide_n;
			east_dy_q    <= east_dy_n;
			diag_dy_q    <= diag_dy_n;
			wide_q       <= wide_n;
			steps_left_q <= steps_n;
		end else if (emit && !last_px) begin
			cur_x_q      <= cur_x_q + CB'(diag | east_dx_q);
			cur_y_q      <= cur_y_q + CB'(diag ? diag_dy_q : east_dy_q);
			dec_q        <= dec_q + (diag ? diag_step_q : east_step_q);
			cur_depth_q  <= cur_depth_q + depth_step_q;
			steps_left_q <= steps_left_q - 1'b1;
		end
		if (div_done) begin
			depth_step_q <= div_quo;
		end
	end

	// Pixel output register.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.pixel_x     <= cur_x_q;
			out_q.pixel_y     <= cur_y_q;
			out_q.pixel_depth <= cur_depth_q;
			out_q.visible     <= vis;
			out_q.last        <= last_px;
		end
	end

	assign pixel.valid      = out_valid_q;
	assign pixel.data       = out_q;
	assign status.div_done  = div_done;
	assign status.out_stall = out_valid_q && !pixel.ready;

	// A new pixel only shows up after a tick on an active line.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(emit))
		else $error("pixel output without an active tick");

	// Emitting the final pixel ends the line.
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_px && !cmd.load) |=> !active_q)
		else $error("line still active after its last pixel");

endmodule

// File: rtl/lrd_ctrl.sv
// ----------------------------------------------------------------------------
// lrd_ctrl: controller of the line rasterizer
// Accepts requests, starts line setup, and waits for the depth division.
// ----------------------------------------------------------------------------
module lrd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	lrd_item_if.sink              item,
	input  lrd_pkg::ctrl_status_t status,
	output lrd_pkg::ctrl_cmd_t    cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic state_q;
	logic accept;

	// A request is taken when idle and the pixel register can move on.
	assign item.ready = (state_q == ST_IDLE) && !status.out_stall;
	assign accept     = item.valid && item.ready;
	assign cmd.load   = accept && (item.data.kind == lrd_pkg::KIND_LOAD);
	assign cmd.tick   = accept && (item.data.kind == lrd_pkg::KIND_TICK);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (status.div_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// No request is taken while the depth step is still being divided.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> !item.ready)
		else $error("request accepted during division");

	// A load always enters the division wait.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_DIV))
		else $error("load did not start division");

endmodule

// File: rtl/line_rasterizer_with_depth_top.sv
// ----------------------------------------------------------------------------
// line_rasterizer_with_depth_top: midpoint line rasterizer with depth
// Loads two endpoints, then emits one pixel per tick request with x, y,
// interpolated depth, a window visibility flag and a last-pixel flag.
//
//   channel  dir  handshake       payload
//   item     in   valid / ready   kind, start_x/y/depth, end_x/y/depth
//   pixel    out  valid / ready   pixel_x, pixel_y, pixel_depth, visible, last
//   cfg      in   valid / ready   index (0 width, 1 height), data
//
// Ticks can follow back to back while the pixel output is not stalled.
// A load request holds the input while the serial divider produces the
// depth step, one quotient bit per cycle.
// Reset is asynchronous and active low; it ends any line and restores the
// 500 by 500 window. The pixel sits in an output register, and the input is
// held while that register holds a pixel that the receiver does not take.
// ----------------------------------------------------------------------------
module line_rasterizer_with_depth_top (
	input  logic        clk,
	input  logic        arst_n,
	lrd_cfg_if.sink     cfg,
	lrd_item_if.sink    item,
	lrd_pixel_if.source pixel
);

	lrd_pkg::ctrl_cmd_t    cmd;
	lrd_pkg::ctrl_status_t status;

	lrd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.status (status),
		.cmd    (cmd)
	);

	lrd_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_data (item.data),
		.cmd       (cmd),
		.status    (status),
		.cfg       (cfg),
		.pixel     (pixel)
	);

endmodule
